>>> design/assert_macros.svh
// Assertion helpers shared by the RTL. All checks are sampled on clk and
// are masked while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

// Whenever ante holds, cons must hold in the same cycle.
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

`endif

>>> design/wbs_pkg.sv
`timescale 1ns / 1ps

package wbs_pkg;

    localparam int SYM_W = 8;

    // item kinds
    localparam logic [1:0] KIND_DICT  = 2'd0;
    localparam logic [1:0] KIND_TEXT  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } wbs_item_t;

    typedef struct packed {
        logic segmentable;
        logic dictionary_dropped;
    } wbs_verdict_t;

    // per-cycle commands broadcast to every cell of the window chain
    typedef struct packed {
        logic shift_text;
        logic shift_load;
        logic clear_reach;
    } wbs_cell_ctrl_t;

endpackage

>>> design/wbs_cell.sv
`timescale 1ns / 1ps

// One window position: text byte and reachability of the position one
// further back, plus one byte of the word being loaded (newest byte in cell 0).
module wbs_cell
    import wbs_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int LEN_W = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  wbs_cell_ctrl_t   ctrl,
    input  logic [SYM_W-1:0] text_in,
    input  logic             reach_in,
    input  logic [SYM_W-1:0] load_in,
    input  logic [SYM_W-1:0] row_char,
    input  logic [LEN_W-1:0] row_len,
    output logic [SYM_W-1:0] text_out,
    output logic             reach_out,
    output logic [SYM_W-1:0] load_out,
    output logic             ok,
    output logic             sel
);

    logic [SYM_W-1:0] text_reg;
    logic [SYM_W-1:0] load_reg;
    logic             reach_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reach_reg <= 1'b0;
        end
        else if (ctrl.clear_reach)
        begin
            reach_reg <= 1'b0;
        end
        else if (ctrl.shift_text)
        begin
            reach_reg <= reach_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift_text)
        begin
            text_reg <= text_in;
        end
        if (ctrl.shift_load)
        begin
            load_reg <= load_in;
        end
    end

    // positions at or past the word length do not take part
    assign ok        = (row_len <= LEN_W'(IDX)) || (text_reg == row_char);
    // reach_reg is the bit IDX+1 positions back: the start of a word of that length
    assign sel       = reach_reg && (row_len == LEN_W'(IDX + 1));
    assign text_out  = text_reg;
    assign reach_out = reach_reg;
    assign load_out  = load_reg;

endmodule

>>> design/word_break_segmentability.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Word-break checker. One input channel (item/item_valid/item_stall) takes
// dictionary bytes, text bytes, end-of-text and clear-dictionary items; one
// output channel (verdict/verdict_valid/verdict_stall) returns a verdict for
// each text that ends.
// A dictionary byte that completes a stored word passes through a commit
// state that writes the row; a text byte scans the stored words (one row of
// the dictionary memory read and compared per cycle against the window
// cells) and then a wait state, or neither with an empty dictionary; a text
// end (final byte or end item) passes through an emit state that places the
// verdict. No new item is taken until the block is back in idle.
// A finished verdict sits in the output register; new items are taken while
// it waits, but the next verdict holds the block until the receiver takes
// the previous one (verdict_stall low).
// Reset empties the dictionary, clears the dropped flag and returns the
// text window to its start position; no clearing pass is needed.
module word_break_segmentability
    import wbs_pkg::*;
#(
    parameter int DICT_WORDS = 64,
    parameter int MAX_WORD   = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  wbs_item_t    item,
    output logic         verdict_valid,
    input  logic         verdict_stall,
    output wbs_verdict_t verdict
);

    localparam int LEN_W = $clog2(MAX_WORD + 1);
    localparam int CNT_W = $clog2(DICT_WORDS + 1);
    localparam int AW    = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;
    localparam int ROW_W = LEN_W + MAX_WORD * SYM_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMMIT,
        ST_SCAN,
        ST_WAIT,
        ST_EMIT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    logic [LEN_W-1:0] pos_reg;
    logic             overlong_reg;
    logic             dropped_reg;
    logic             reach0_reg;
    logic             hit_reg;
    logic             text_last_reg;
    logic [AW-1:0]    scan_idx_reg;
    logic             cmp_valid_reg;
    logic [AW-1:0]    commit_addr_reg;
    logic [LEN_W-1:0] commit_len_reg;
    logic             verdict_valid_reg;
    wbs_verdict_t     verdict_reg;

    logic [ROW_W-1:0] dict_mem [DICT_WORDS];
    logic [ROW_W-1:0] row_reg;

    logic             accept;
    logic             out_free;
    logic             overlong_now;
    logic             room;
    logic             hit_next;
    logic             match;
    wbs_cell_ctrl_t   cell_ctrl;
    logic [LEN_W-1:0] row_len;

    logic [SYM_W-1:0] text_chain  [MAX_WORD];
    logic             reach_chain [MAX_WORD];
    logic [SYM_W-1:0] load_chain  [MAX_WORD];
    logic [MAX_WORD-1:0] ok_vec;
    logic [MAX_WORD-1:0] sel_vec;
    logic [MAX_WORD*SYM_W-1:0] load_row;

    assign accept       = item_valid && !item_stall;
    assign item_stall   = (state_reg != ST_IDLE);
    assign out_free     = !verdict_valid_reg || !verdict_stall;
    assign overlong_now = overlong_reg || (pos_reg == LEN_W'(MAX_WORD));
    assign room         = (count_reg < CNT_W'(DICT_WORDS));

    always_comb
    begin
        cell_ctrl.shift_text  = accept && (item.kind == KIND_TEXT);
        cell_ctrl.shift_load  = accept && (item.kind == KIND_DICT) && !overlong_now;
        cell_ctrl.clear_reach = (state_reg == ST_EMIT) && out_free;
    end

    assign row_len  = row_reg[ROW_W-1 -: LEN_W];
    assign match    = (&ok_vec) && (|sel_vec);
    assign hit_next = hit_reg || (cmp_valid_reg && match);

    genvar d;
    generate
        for (d = 0; d < MAX_WORD; d++)
        begin : g_cell
            logic [SYM_W-1:0] text_in;
            logic             reach_in;
            logic [SYM_W-1:0] load_in;

            if (d == 0)
            begin : g_head
                assign text_in  = item.symbol;
                assign reach_in = reach0_reg;
                assign load_in  = item.symbol;
            end
            else
            begin : g_body
                assign text_in  = text_chain[d-1];
                assign reach_in = reach_chain[d-1];
                assign load_in  = load_chain[d-1];
            end

            wbs_cell #(
                .IDX   (d),
                .LEN_W (LEN_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl),
                .text_in   (text_in),
                .reach_in  (reach_in),
                .load_in   (load_in),
                .row_char  (row_reg[d*SYM_W +: SYM_W]),
                .row_len   (row_len),
                .text_out  (text_chain[d]),
                .reach_out (reach_chain[d]),
                .load_out  (load_chain[d]),
                .ok        (ok_vec[d]),
                .sel       (sel_vec[d])
            );

            assign load_row[d*SYM_W +: SYM_W] = load_chain[d];
        end
    endgenerate

    // dictionary rows: {length, bytes with the final byte at position 0}
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_COMMIT)
        begin
            dict_mem[commit_addr_reg] <= {commit_len_reg, load_row};
        end
        row_reg <= dict_mem[scan_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            count_reg         <= '0;
            pos_reg           <= '0;
            overlong_reg      <= 1'b0;
            dropped_reg       <= 1'b0;
            reach0_reg        <= 1'b1;
            hit_reg           <= 1'b0;
            text_last_reg     <= 1'b0;
            scan_idx_reg      <= '0;
            cmp_valid_reg     <= 1'b0;
            commit_addr_reg   <= '0;
            commit_len_reg    <= '0;
            verdict_valid_reg <= 1'b0;
            verdict_reg       <= '0;
        end
        else
        begin
            cmp_valid_reg <= (state_reg == ST_SCAN);
            hit_reg       <= hit_next;
            if (verdict_valid_reg && !verdict_stall)
            begin
                verdict_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (item.kind)
                            KIND_DICT:
                            begin
                                if (!overlong_now)
                                begin
                                    pos_reg <= pos_reg + LEN_W'(1);
                                end
                                else
                                begin
                                    overlong_reg <= 1'b1;
                                end
                                if (item.last)
                                begin
                                    pos_reg      <= '0;
                                    overlong_reg <= 1'b0;
                                    if (!overlong_now && room)
                                    begin
                                        commit_addr_reg <= count_reg[AW-1:0];
                                        commit_len_reg  <= pos_reg + LEN_W'(1);
                                        count_reg       <= count_reg + CNT_W'(1);
                                        state_reg       <= ST_COMMIT;
                                    end
                                    else
                                    begin
                                        dropped_reg <= 1'b1;
                                    end
                                end
                            end
                            KIND_TEXT:
                            begin
                                reach0_reg    <= 1'b0;
                                hit_reg       <= 1'b0;
                                text_last_reg <= item.last;
                                scan_idx_reg  <= '0;
                                if (count_reg != '0)
                                begin
                                    state_reg <= ST_SCAN;
                                end
                                else if (item.last)
                                begin
                                    state_reg <= ST_EMIT;
                                end
                            end
                            KIND_END:
                            begin
                                state_reg <= ST_EMIT;
                            end
                            default:
                            begin
                                count_reg    <= '0;
                                pos_reg      <= '0;
                                overlong_reg <= 1'b0;
                                dropped_reg  <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_COMMIT:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_SCAN:
                begin
                    if (CNT_W'(scan_idx_reg) + CNT_W'(1) == count_reg)
                    begin
                        state_reg <= ST_WAIT;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + AW'(1);
                    end
                end
                ST_WAIT:
                begin
                    // last row compare lands this cycle
                    reach0_reg <= hit_next;
                    state_reg  <= text_last_reg ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        verdict_valid_reg              <= 1'b1;
                        verdict_reg.segmentable        <= reach0_reg;
                        verdict_reg.dictionary_dropped <= dropped_reg;
                        reach0_reg                     <= 1'b1;
                        state_reg                      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign verdict_valid = verdict_valid_reg;
    assign verdict       = verdict_reg;

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(DICT_WORDS))
    `ASSERT_ALWAYS(a_pos_bound, pos_reg <= LEN_W'(MAX_WORD))
    `ASSERT_IMPLY(a_verdict_from_emit, $rose(verdict_valid_reg), $past(state_reg == ST_EMIT))
    `ASSERT_IMPLY(a_cmp_after_scan, cmp_valid_reg, $past(state_reg == ST_SCAN))

endmodule
